// File: hw/rtl/snaff_pkg.sv
// Shared types and constants for the SNA frame fragmenter.
// No dependencies; every other RTL file imports this package.
`default_nettype none

package snaff_pkg;

	// Default transmission-header length in bytes
	localparam int HEADER_BYTES_DEF = 6;

	// Reset value of the largest fragment size register
	localparam logic [15:0] FRAG_LIMIT_RESET = 16'd265;

	// Mapping-field bits in header byte 0
	localparam int SEG_BEGIN_BIT = 3;
	localparam int SEG_END_BIT   = 2;

	// One input byte of a frame
	typedef struct packed {
		logic [7:0]  data_byte;
		logic [15:0] frame_length;
		logic        frame_start;
	} in_t;

	// One output byte of a fragment
	typedef struct packed {
		logic [7:0] out_byte;
		logic       fragment_end;
		logic       frame_end;
		logic       run_last;
	} out_t;

	// Work handed from the frame tracker to the output sequencer
	typedef struct packed {
		logic [7:0] byte0;    // header byte 0 with segment bits already fixed
		logic [7:0] data;     // payload byte
		logic       fe;       // payload byte closes its fragment
		logic       fre;      // payload byte closes the frame
		logic       replay;   // fragment opens here: header copy goes first
	} job_t;

endpackage

`default_nettype wire

// File: hw/rtl/snaff_core.sv
// Frame tracker: byte position, length, fragment fill, header store.
// Depends on snaff_pkg. Builds one job per payload byte for snaff_emit.
`default_nettype none

module snaff_core #(
	parameter int HEADER_BYTES = snaff_pkg::HEADER_BYTES_DEF,
	parameter int IDXW         = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             accept,
	input  wire snaff_pkg::in_t   req,
	input  wire logic [15:0]      frag_limit,
	output      logic             job_load,
	output      snaff_pkg::job_t  job,
	input  wire logic [IDXW-1:0]  rd_idx,
	output      logic [7:0]       rd_byte
);
	import snaff_pkg::*;

	localparam logic [15:0] HDR_LEN = 16'(HEADER_BYTES);

	logic [15:0] pos_q;
	logic [15:0] len_q;
	logic [15:0] fill_q;
	logic [1:0]  seg_q;
	logic [7:0]  store_q [HEADER_BYTES];

	logic [15:0] pos_eff;
	logic [15:0] len_eff;
	logic [15:0] fill_eff;
	logic [15:0] room;
	logic [15:0] fill_new;
	logic [15:0] pos_next;
	logic        active;
	logic        in_hdr;
	logic        first;
	logic        last;
	logic [7:0]  b0;

	// frame_start restarts the frame in the same step
	always_comb begin
		pos_eff  = req.frame_start ? '0 : pos_q;
		len_eff  = req.frame_start ? req.frame_length : len_q;
		fill_eff = req.frame_start ? '0 : fill_q;
		active   = pos_eff < len_eff;
		in_hdr   = pos_eff < HDR_LEN;
		room     = (frag_limit > HDR_LEN) ? (frag_limit - HDR_LEN) : 16'd1;
		pos_next = pos_eff + 16'd1;
		fill_new = fill_eff + 16'd1;
		first    = pos_eff == HDR_LEN;
		last     = (len_eff - pos_eff) <= room;
	end

	// Header byte 0 copy: segment bits rebuilt per fragment
	always_comb begin
		b0 = store_q[0];
		b0[SEG_BEGIN_BIT] = first && seg_q[1];
		b0[SEG_END_BIT]   = last && seg_q[0];
	end

	// Job for the output side
	always_comb begin
		job_load   = accept && active && !in_hdr;
		job.byte0  = b0;
		job.data   = req.data_byte;
		job.fre    = pos_next == len_eff;
		job.fe     = job.fre || (fill_new >= room);
		job.replay = fill_eff == '0;
	end

	assign rd_byte = store_q[rd_idx];

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			len_q  <= '0;
			fill_q <= '0;
			seg_q  <= '0;
		end else if (accept) begin
			len_q <= len_eff;
			if (!active) begin
				pos_q  <= pos_eff;
				fill_q <= fill_eff;
			end else if (in_hdr) begin
				pos_q  <= pos_next;
				fill_q <= fill_eff;
				if (pos_eff == '0) begin
					seg_q <= {req.data_byte[SEG_BEGIN_BIT], req.data_byte[SEG_END_BIT]};
				end
			end else begin
				pos_q  <= pos_next;
				fill_q <= job.fe ? '0 : fill_new;
			end
		end
	end

	// Header store, written once per header byte
	always_ff @(posedge clk) begin
		if (accept && active && in_hdr) begin
			store_q[pos_eff[IDXW-1:0]] <= req.data_byte;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/snaff_emit.sv
// Output sequencer: holds one job, replays the header, drives the result register.
// Depends on snaff_pkg; reads header bytes from snaff_core.
`default_nettype none

module snaff_emit #(
	parameter int HEADER_BYTES = snaff_pkg::HEADER_BYTES_DEF,
	parameter int IDXW         = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             job_load,
	input  wire snaff_pkg::job_t  job,
	output      logic             busy,
	output      logic [IDXW-1:0]  rd_idx,
	input  wire logic [7:0]       rd_byte,
	output      logic             valid,
	input  wire logic             stall,
	output      snaff_pkg::out_t  data
);
	import snaff_pkg::*;

	localparam int CNTW = $clog2(HEADER_BYTES + 1);
	localparam logic [CNTW-1:0] CNT_PAY = CNTW'(HEADER_BYTES);

	job_t            job_q;
	logic            job_valid_q;
	logic [CNTW-1:0] cnt_q;
	logic            out_valid_q;
	out_t            out_q;

	logic advance;
	logic on_pay;
	logic job_done;
	out_t nxt;

	// Next result of the held job
	always_comb begin
		on_pay   = cnt_q == CNT_PAY;
		advance  = job_valid_q && (!out_valid_q || !stall);
		job_done = advance && on_pay;
		rd_idx   = cnt_q[IDXW-1:0];
		busy     = job_valid_q && !job_done;
		nxt.out_byte     = on_pay ? job_q.data : ((cnt_q == '0) ? job_q.byte0 : rd_byte);
		nxt.fragment_end = on_pay && job_q.fe;
		nxt.frame_end    = on_pay && job_q.fre;
		nxt.run_last     = on_pay;
	end

	// Job register and replay counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else if (job_load) begin
			job_valid_q <= 1'b1;
			cnt_q       <= job.replay ? '0 : CNT_PAY;
		end else if (job_done) begin
			job_valid_q <= 1'b0;
		end else if (advance) begin
			cnt_q <= cnt_q + CNTW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (job_load) begin
			job_q <= job;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= nxt;
		end
	end

	assign valid = out_valid_q;
	assign data  = out_q;

endmodule

`default_nettype wire

// File: hw/rtl/sna_frame_fragmenter.sv
// SNA frame fragmenter top level: config register, frame tracker, output sequencer.
// Path: an accepted request is held in the job register, then its first result is registered in the result register.
// Throughput: 1 request per cycle when the output does not stall; a byte that opens a fragment
// stalls the input while the header copy goes out before it.
// Reset: control state cleared, max_fragment_size = 265; header store is not cleared.
`default_nettype none

module sna_frame_fragmenter #(
	parameter int HEADER_BYTES = snaff_pkg::HEADER_BYTES_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             src_valid,
	output      logic             src_stall,
	input  wire snaff_pkg::in_t   src_data,
	output      logic             dst_valid,
	input  wire logic             dst_stall,
	output      snaff_pkg::out_t  dst_data,
	input  wire logic             cfg_wr_en,
	input  wire logic [15:0]      cfg_wr_data
);
	import snaff_pkg::*;

	localparam int IDXW = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;

	logic [15:0]     frag_limit_q;
	logic            accept;
	logic            job_load;
	job_t            job;
	logic            busy;
	logic [IDXW-1:0] rd_idx;
	logic [7:0]      rd_byte;

	// Fragment size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frag_limit_q <= FRAG_LIMIT_RESET;
		end else if (cfg_wr_en) begin
			frag_limit_q <= cfg_wr_data;
		end
	end

	assign src_stall = busy;
	assign accept    = src_valid && !busy;

	snaff_core #(
		.HEADER_BYTES(HEADER_BYTES),
		.IDXW(IDXW)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.req(src_data),
		.frag_limit(frag_limit_q),
		.job_load(job_load),
		.job(job),
		.rd_idx(rd_idx),
		.rd_byte(rd_byte)
	);

	snaff_emit #(
		.HEADER_BYTES(HEADER_BYTES),
		.IDXW(IDXW)
	) u_emit (
		.clk(clk),
		.arst_n(arst_n),
		.job_load(job_load),
		.job(job),
		.busy(busy),
		.rd_idx(rd_idx),
		.rd_byte(rd_byte),
		.valid(dst_valid),
		.stall(dst_stall),
		.data(dst_data)
	);

	// Header copy bytes never close a fragment or a frame
	a_hdr_no_end: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && !dst_data.run_last |-> !dst_data.fragment_end && !dst_data.frame_end)
		else $error("header copy byte flagged as fragment or frame end");

	// Frame end is always the closing byte of a fragment
	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_data.frame_end |-> dst_data.fragment_end && dst_data.run_last)
		else $error("frame end without fragment end");

	// No job may be loaded while the sequencer is still busy with the last one
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		job_load |-> !busy)
		else $error("job loaded while sequencer busy");

endmodule

`default_nettype wire
